// ===== rtl/alfc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alfc_pkg
// Shared types and constants of the cross-shaped adaptive loop filter.
// ---------------------------------------------------------------------------
package alfc_pkg;

   // Sample width carried on the ports.
   localparam int PIXEL_BITS  = 10;
   // Coefficient lanes are signed 16-bit values.
   localparam int COEF_W      = 16;
   localparam int NUM_PAIRS   = 8;
   // Sum of two pixels, and the signed product of a coefficient with it.
   localparam int PAIR_W      = PIXEL_BITS + 1;
   localparam int PROD_W      = COEF_W + PAIR_W + 1;
   // Nine products need four guard bits.
   localparam int SUM_W       = PROD_W + 4;
   localparam int ROUND_ADD   = 32;
   localparam int ROUND_SHIFT = 6;
   localparam int MIN_DEPTH   = 8;
   localparam int FILL_FULL   = 6;
   localparam int FILL_W      = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_COEF_A    = 2'd0,
      CSR_COEF_B    = 2'd1,
      CSR_COEF_CTR  = 2'd2,
      CSR_BIT_DEPTH = 2'd3
   } csr_index_type;

   // One input word: a seven-row pixel column plus row markers.
   typedef struct packed {
      logic [PIXEL_BITS-1:0] pix_up3;
      logic [PIXEL_BITS-1:0] pix_up2;
      logic [PIXEL_BITS-1:0] pix_up1;
      logic [PIXEL_BITS-1:0] pix_mid;
      logic [PIXEL_BITS-1:0] pix_dn1;
      logic [PIXEL_BITS-1:0] pix_dn2;
      logic [PIXEL_BITS-1:0] pix_dn3;
      logic [1:0]            rows_above;
      logic [1:0]            rows_below;
      logic                  row_first;
      logic                  row_end;
   } req_word_type;

   // One result word.
   typedef struct packed {
      logic [PIXEL_BITS-1:0] filtered_pixel;
      logic                  last_in_row;
   } rsp_word_type;

   // Outer rows of one column after row clamping.
   typedef struct packed {
      logic [PIXEL_BITS-1:0] dn3;
      logic [PIXEL_BITS-1:0] dn2;
      logic [PIXEL_BITS-1:0] up2;
      logic [PIXEL_BITS-1:0] up3;
   } outer_type;

   // Symmetric tap pairs already summed, handed from front to back.
   typedef struct packed {
      logic [NUM_PAIRS-1:0][PAIR_W-1:0] pair;
      logic [PIXEL_BITS-1:0]            center;
      logic                             last;
   } tap_word_type;

   // Configuration registers as seen by the arithmetic.
   typedef struct packed {
      logic [4*COEF_W-1:0] coef_a;
      logic [4*COEF_W-1:0] coef_b;
      logic [COEF_W-1:0]   coef_center;
      logic [3:0]          bit_depth;
   } cfg_type;

endpackage

// ===== rtl/alfc_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alfc_front
// Takes in pixel columns, clamps rows, keeps the column window and, once
// the window is full, pushes the summed tap pairs to the queue.
// ---------------------------------------------------------------------------
module alfc_front import alfc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   input  logic         queue_full,
   output logic         push_valid,
   output tap_word_type push_data
);

   logic [PIXEL_BITS-1:0] center_hist_ff [FILL_FULL];
   logic [PIXEL_BITS-1:0] above_hist_ff  [4];
   logic [PIXEL_BITS-1:0] below_hist_ff  [4];
   outer_type             outer_hist_ff  [3];
   logic [FILL_W-1:0]     fill_ff;
   logic [FILL_W-1:0]     fill_start;
   logic [FILL_W-1:0]     fill_in;
   logic                  accept;
   logic                  emit;
   logic [PIXEL_BITS-1:0] u1, u2, u3, d1, d2, d3;
   outer_type             outer_new;
   outer_type             outer_old;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Clamp the vertical offsets to the rows that exist.
   always_comb begin
      u1 = (req_data.rows_above == 2'd0) ? req_data.pix_mid : req_data.pix_up1;
      d1 = (req_data.rows_below == 2'd0) ? req_data.pix_mid : req_data.pix_dn1;
      case (req_data.rows_above)
         2'd0:    begin u2 = req_data.pix_mid; u3 = req_data.pix_mid; end
         2'd1:    begin u2 = req_data.pix_up1; u3 = req_data.pix_up1; end
         2'd2:    begin u2 = req_data.pix_up2; u3 = req_data.pix_up2; end
         default: begin u2 = req_data.pix_up2; u3 = req_data.pix_up3; end
      endcase
      case (req_data.rows_below)
         2'd0:    begin d2 = req_data.pix_mid; d3 = req_data.pix_mid; end
         2'd1:    begin d2 = req_data.pix_dn1; d3 = req_data.pix_dn1; end
         2'd2:    begin d2 = req_data.pix_dn2; d3 = req_data.pix_dn2; end
         default: begin d2 = req_data.pix_dn2; d3 = req_data.pix_dn3; end
      endcase
      outer_new = '{dn3: d3, dn2: d2, up2: u2, up3: u3};
   end

   // Window fill count: the first column of a row restarts it, the last
   // column of a row clears it after use.
   always_comb begin
      fill_start = req_data.row_first ? '0 : fill_ff;
      emit       = (fill_start >= FILL_W'(FILL_FULL));
      fill_in    = emit ? fill_start : fill_start + FILL_W'(1);
      if (req_data.row_end) begin
         fill_in = '0;
      end
   end

   // Pair up the symmetric taps around the center column.
   always_comb begin
      outer_old = outer_hist_ff[2];
      push_data.pair[0] = PAIR_W'(outer_old.up3) + PAIR_W'(outer_old.dn3);
      push_data.pair[1] = PAIR_W'(outer_old.up2) + PAIR_W'(outer_old.dn2);
      push_data.pair[2] = PAIR_W'(above_hist_ff[3]) + PAIR_W'(below_hist_ff[1]);
      push_data.pair[3] = PAIR_W'(above_hist_ff[2]) + PAIR_W'(below_hist_ff[2]);
      push_data.pair[4] = PAIR_W'(above_hist_ff[1]) + PAIR_W'(below_hist_ff[3]);
      push_data.pair[5] = PAIR_W'(center_hist_ff[5]) + PAIR_W'(req_data.pix_mid);
      push_data.pair[6] = PAIR_W'(center_hist_ff[4]) + PAIR_W'(center_hist_ff[0]);
      push_data.pair[7] = PAIR_W'(center_hist_ff[3]) + PAIR_W'(center_hist_ff[1]);
      push_data.center  = center_hist_ff[2];
      push_data.last    = req_data.row_end;
   end

   assign push_valid = accept && emit;

   // Column window shift registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         for (int i = 0; i < FILL_FULL; i++) center_hist_ff[i] <= '0;
         for (int i = 0; i < 4; i++) begin
            above_hist_ff[i] <= '0;
            below_hist_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) outer_hist_ff[i] <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
         for (int i = FILL_FULL - 1; i > 0; i--) center_hist_ff[i] <= center_hist_ff[i-1];
         center_hist_ff[0] <= req_data.pix_mid;
         for (int i = 3; i > 0; i--) begin
            above_hist_ff[i] <= above_hist_ff[i-1];
            below_hist_ff[i] <= below_hist_ff[i-1];
         end
         above_hist_ff[0] <= u1;
         below_hist_ff[0] <= d1;
         for (int i = 2; i > 0; i--) outer_hist_ff[i] <= outer_hist_ff[i-1];
         outer_hist_ff[0] <= outer_new;
      end
   end

endmodule

// ===== rtl/alfc_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alfc_queue
// Short first-in first-out queue of tap words between front and back.
// ---------------------------------------------------------------------------
module alfc_queue import alfc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  tap_word_type push_data,
   output logic         full,
   output logic         pop_valid,
   input  logic         pop_ready,
   output tap_word_type pop_data
);

   tap_word_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + QCNT_W'(1);
            2'b01:   count_ff <= count_ff - QCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== rtl/alfc_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alfc_back
// Multiply-accumulate pipeline: products, partial sums, rounding, clipping
// into the output register.
// ---------------------------------------------------------------------------
module alfc_back import alfc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         tap_valid,
   output logic         tap_ready,
   input  tap_word_type tap_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   logic signed [COEF_W-1:0] coef [NUM_PAIRS];
   logic signed [PROD_W-1:0] prod_ff [NUM_PAIRS + 1];
   logic signed [PROD_W-1:0] prod_in [NUM_PAIRS + 1];
   logic signed [SUM_W-1:0]  part_ff [3];
   logic signed [SUM_W-1:0]  part_in [3];
   logic signed [SUM_W-1:0]  total_ff;
   logic signed [SUM_W-1:0]  total_in;
   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic                     s1_last_ff, s2_last_ff, s3_last_ff;
   rsp_word_type             out_ff;
   rsp_word_type             out_in;
   logic                     advance;
   logic [3:0]               depth;
   logic [SUM_W-1:0]         max_val;
   logic [SUM_W-1:0]         shifted;

   // The whole pipeline moves when the output register can take a word.
   assign advance   = !out_valid_ff || rsp_ready;
   assign tap_ready = advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Coefficient lanes, low lane first in each group.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         coef[k]     = cfg.coef_a[k*COEF_W +: COEF_W];
         coef[k + 4] = cfg.coef_b[k*COEF_W +: COEF_W];
      end
   end

   // Stage one: one multiply per tap pair plus the center tap.
   always_comb begin
      for (int k = 0; k < NUM_PAIRS; k++) begin
         prod_in[k] = coef[k] * $signed({1'b0, tap_data.pair[k]});
      end
      prod_in[NUM_PAIRS] = $signed(cfg.coef_center)
                         * $signed({2'b00, tap_data.center});
   end

   // Stage two: three partial sums of three products each.
   always_comb begin
      for (int g = 0; g < 3; g++) begin
         part_in[g] = SUM_W'(prod_ff[3*g]) + SUM_W'(prod_ff[3*g + 1])
                    + SUM_W'(prod_ff[3*g + 2]);
      end
   end

   // Stage three: total with the rounding offset.
   assign total_in = part_ff[0] + part_ff[1] + part_ff[2] + SUM_W'(ROUND_ADD);

   // Stage four: shift down and clip to the sample range.
   always_comb begin
      depth = cfg.bit_depth;
      if (depth < 4'(MIN_DEPTH))  depth = 4'(MIN_DEPTH);
      if (depth > 4'(PIXEL_BITS)) depth = 4'(PIXEL_BITS);
      max_val = (SUM_W'(1) << depth) - SUM_W'(1);
      shifted = SUM_W'(total_ff >>> ROUND_SHIFT);
      if (total_ff < 0) begin
         out_in.filtered_pixel = '0;
      end else if (shifted > max_val) begin
         out_in.filtered_pixel = max_val[PIXEL_BITS-1:0];
      end else begin
         out_in.filtered_pixel = shifted[PIXEL_BITS-1:0];
      end
      out_in.last_in_row = s3_last_ff;
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= tap_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= NUM_PAIRS; k++) prod_ff[k] <= prod_in[k];
         for (int g = 0; g < 3; g++) part_ff[g] <= part_in[g];
         total_ff   <= total_in;
         out_ff     <= out_in;
         s1_last_ff <= tap_data.last;
         s2_last_ff <= s1_last_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

endmodule

// ===== rtl/adaptive_loop_filter_cross.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// adaptive_loop_filter_cross
// Symmetric 17-tap loop filter, 7x7 cross plus 3x3 square, one column per
// clock while the queue has room.
// ---------------------------------------------------------------------------
// The block takes one seven-row pixel column per clock while the queue has
// room and, once six columns of the current row are held, returns the
// filtered pixel of the column three back, one word per clock while the
// result side is ready. The front end clamps rows, keeps the window and sums
// symmetric tap pairs in the cycle a column is taken; a four-word queue then
// feeds a four-stage multiply, add, round and clip pipeline. The queue depth
// sets how long the result side may stall before the column side stops.
// Configuration is written through the csr port (always ready); users must
// write it only while no column is in flight; the block does not check it.
// ---------------------------------------------------------------------------
module adaptive_loop_filter_cross import alfc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_word_type  req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_word_type  rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [63:0]   csr_data
);

   cfg_type      cfg_ff;
   logic         push_valid;
   tap_word_type push_data;
   logic         queue_full;
   logic         tap_valid;
   logic         tap_ready;
   tap_word_type tap_data;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_a      <= '0;
         cfg_ff.coef_b      <= '0;
         cfg_ff.coef_center <= COEF_W'(64);
         cfg_ff.bit_depth   <= 4'(MIN_DEPTH);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COEF_A:    cfg_ff.coef_a      <= csr_data;
            CSR_COEF_B:    cfg_ff.coef_b      <= csr_data;
            CSR_COEF_CTR:  cfg_ff.coef_center <= csr_data[COEF_W-1:0];
            CSR_BIT_DEPTH: cfg_ff.bit_depth   <= csr_data[3:0];
            default:       cfg_ff             <= cfg_ff;
         endcase
      end
   end

   alfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   alfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (tap_valid),
      .pop_ready  (tap_ready),
      .pop_data   (tap_data)
   );

   alfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .tap_valid (tap_valid),
      .tap_ready (tap_ready),
      .tap_data  (tap_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/alfc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alfc_checker
// Port-level checks of the loop filter, bound to the top level.
// ---------------------------------------------------------------------------
module alfc_checker import alfc_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_data,
   input logic         csr_ready
);

   // A stalled result word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Reset empties the result pipeline.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A first result cannot appear until the pipeline has filled after reset.
   a_rsp_latency: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
      else $error("result appeared too soon after reset");

   // After reset the queue is empty, so columns are taken at once.
   a_req_after_reset: assert property (@(posedge clock)
      reset |=> req_ready && csr_ready)
      else $error("input not ready after reset");

endmodule

bind adaptive_loop_filter_cross alfc_checker u_alfc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
